[sv/sha256_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    localparam t_word InitChain [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage
`default_nettype wire

[sv/sha256_stream_hasher_top.sv]
// SHA-256 byte-stream hasher.
// Input channel (i_valid/o_ready): one item per transfer, i_data_byte qualified by
// i_byte_present, i_end_of_message closing the message (may carry no byte).
// Output channel (o_valid/i_ready): eight digest words, index 0..7, last marked.
// Bytes are packed straight into the sixteen schedule words, so after a plain
// byte the next item can follow at once. The 64th byte of a block keeps o_ready
// low for a load, the 64 rounds of the single round unit and a chaining add.
// The block takes no new byte until that compression is done.
// A final item fills the rest of the block one byte per cycle (0x80, zeros,
// bit length), then compresses; if the fill starts at byte 56 or later a second
// fill of a whole block and its compression follow. The digest words are then
// offered one word per cycle while i_ready is high. o_ready stays low while a
// block is padded or compressed or digest words are pending; a stalled receiver
// holds the current word and the block waits.
// Reset restores the initial chaining values and a zero bit count; schedule
// and working words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_top (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  wire  logic [7:0]  i_data_byte,
    input  wire  logic        i_byte_present,
    input  wire  logic        i_end_of_message,
    output logic              o_valid,
    input  wire  logic        i_ready,
    output sha256_pkg::t_word o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_len;
    logic [5:0]  r_pos;         // fill position during padding
    logic        r_mark;        // 0x80 still to be written
    logic        r_fits;        // length field goes into the block being filled
    logic        r_final;       // current compression is the last one
    logic        r_pend;        // padding pending after this compression
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;
    t_word       r_w [16];
    t_word       r_v [8];
    t_word       r_h [8];

    logic [5:0] w_wpos;
    logic       w_take;
    logic       w_full;
    logic [5:0] w_start;
    assign w_wpos  = r_len[8:3];
    assign w_take  = i_valid && o_ready;
    assign w_full  = w_take && i_byte_present && (w_wpos == 6'd63);
    assign w_start = i_byte_present ? w_wpos + 6'd1 : w_wpos;

    // round datapath: schedule expansion and one compression round
    t_word w_w2, w_w15, w_new, w_cur, w_t1, w_t2, w_s1, w_s0;
    always_comb begin
        w_w2  = r_w[14];
        w_w15 = r_w[1];
        w_s1  = rotr(w_w2, 17) ^ rotr(w_w2, 19) ^ (w_w2 >> 10);
        w_s0  = rotr(w_w15, 7) ^ rotr(w_w15, 18) ^ (w_w15 >> 3);
        w_new = w_s1 + r_w[9] + w_s0 + r_w[0];
        w_cur = r_w[0];
        w_t1  = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundConst[r_rnd] + w_cur;
        w_t2  = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // sequence states
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_full) n_state = ST_LOAD;
                else if (w_take && i_end_of_message) n_state = ST_PAD;
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (r_final) n_state = ST_OUT;
                else if (r_pend) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_PAD:   if (r_pos == 6'd63) n_state = ST_LOAD;
            ST_OUT:   if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_pos   <= '0;
            r_mark  <= 1'b0;
            r_fits  <= 1'b0;
            r_final <= 1'b0;
            r_pend  <= 1'b0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitChain[i];
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        if (i_byte_present) r_len <= r_len + 64'd8;
                        r_pos   <= w_start;
                        r_mark  <= i_end_of_message;
                        r_fits  <= (w_start < 6'd56);
                        r_pend  <= i_end_of_message;
                        r_final <= 1'b0;
                    end
                end
                ST_LOAD:  r_rnd <= '0;
                ST_ROUND: r_rnd <= r_rnd + 6'd1;
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    // a further fill always starts a fresh block that takes the length
                    if (!r_final && r_pend) begin
                        r_pos  <= '0;
                        r_fits <= 1'b1;
                    end
                end
                ST_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_mark) r_mark <= 1'b0;
                    if (r_pos == 6'd63) begin
                        r_final <= r_fits;
                        r_pend  <= !r_fits;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitChain[i];
                            r_len <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // padding byte: 0x80 first, then zeros, big-endian bit length in the last eight
    logic [7:0] w_pad;
    logic [2:0] w_lsel;
    assign w_lsel = 3'd7 - r_pos[2:0];
    always_comb begin
        if (r_mark) w_pad = PadByte;
        else if (r_fits && r_pos >= 6'd56) w_pad = r_len[{w_lsel, 3'b000} +: 8];
        else w_pad = 8'd0;
    end

    // schedule and working registers: pack bytes, pad, load and run rounds
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            if (w_take && i_byte_present)
                r_w[w_wpos[5:2]][{~w_wpos[1:0], 3'b000} +: 8] <= i_data_byte;
        end else if (r_state == ST_PAD) begin
            r_w[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= w_pad;
        end else if (r_state == ST_LOAD) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

endmodule
`default_nettype wire

[sv/sha256_stream_hasher_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_word_index,
    input wire logic       o_last_word
);
    // never accept input while digest words are offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while output valid");

    // last flag marks the final index
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last flag mismatch");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_index))
        else $error("output dropped under stall");

    // index advances after each transfer within a digest
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=> o_valid &&
        o_word_index == $past(o_word_index) + 3'd1)
        else $error("index skipped");

    // no digest word right after an input transfer
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("digest word directly after input");
endmodule

bind sha256_stream_hasher_top sha256_stream_hasher_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_word_index(o_word_index),
    .o_last_word(o_last_word)
);
`default_nettype wire

[tb/sv/tb_sha256_stream_hasher_top.sv]
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_top;
    import sha256_pkg::*;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_out;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_present;
    logic        in_eom;
    logic        out_valid;
    logic        out_ready;
    t_word       out_word;
    logic [2:0]  out_index;
    logic        out_last;

    // Predictor state
    t_word       hash_chain [8];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    t_digest_out digest_queue [$];
    int          error_count;
    bit          receiver_running;

    sha256_stream_hasher_top i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_data_byte      (in_byte),
        .i_byte_present   (in_present),
        .i_end_of_message (in_eom),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_digest_word    (out_word),
        .o_word_index     (out_index),
        .o_last_word      (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    function automatic t_word ror32(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one 64-round compression over the collected block
    function automatic void compress_block();
        t_word sched [16];
        t_word v [8];
        t_word s0, s1, t1, t2, w2, w15;
        int    r;
        for (r = 0; r < 16; r++) begin
            sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (r = 0; r < 8; r++) v[r] = hash_chain[r];
        for (r = 0; r < 64; r++) begin
            if (r >= 16) begin
                w2  = sched[(r - 2) & 15];
                w15 = sched[(r - 15) & 15];
                s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
                s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
                sched[r & 15] = s1 + sched[(r - 7) & 15] + s0 + sched[r & 15];
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + sched[r & 15];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) hash_chain[r] += v[r];
    endfunction

    function automatic void reset_digest_state();
        for (int k = 0; k < 8; k++) hash_chain[k] = InitChain[k];
        msg_bits = '0;
    endfunction

    // Absorb one transfer and queue the digest on end of message
    function automatic void absorb_item(logic [7:0] b, logic present, logic eom);
        int pos;
        if (present) begin
            pos = int'(msg_bits[8:3]);
            msg_block[pos] = b;
            msg_bits += 64'd8;
            if (pos == 63) compress_block();
        end
        if (!eom) return;
        pos = int'(msg_bits[8:3]);
        msg_block[pos] = PadByte;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int k = 0; k < 8; k++) msg_block[56 + k] = msg_bits[63 - 8*k -: 8];
        compress_block();
        for (int k = 0; k < 8; k++) begin
            digest_queue.push_back('{hash_chain[k], 3'(k), k == 7});
        end
        reset_digest_state();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Drive one item and hold it until the transfer
    task automatic send_item(logic [7:0] b, logic present, logic eom);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        in_present <= present;
        in_eom     <= eom;
        do @(posedge clk); while (!in_ready);
        absorb_item(b, present, eom);
    endtask

    // Drop valid after the last transfer
    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_message(int len);
        for (int k = 0; k < len; k++) send_item(8'($urandom), 1'b1, 1'b0);
        if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b1, 1'b1);
        else send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        release_input();
        while (digest_queue.size() != 0) @(posedge clk);
    endtask

    // Check each digest word against the oldest expectation
    initial begin
        t_digest_out want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected word", out_word, 32'h0);
                end else begin
                    want = digest_queue.pop_front();
                    if (out_word !== want.word) report_mismatch("digest_word", out_word, want.word);
                    if (out_index !== want.index)
                        report_mismatch("word_index", 32'(out_index), 32'(want.index));
                    if (out_last !== want.last)
                        report_mismatch("last_word", 32'(out_last), 32'(want.last));
                end
            end
        end
    end

    // Wait a random number of cycles before taking each digest word
    initial begin
        int hold;
        out_ready <= 1'b0;
        while (!receiver_running) @(posedge clk);
        forever begin
            hold = $urandom_range(0, 9);
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_directed_bytes();
        // idle item with neither byte nor end mark
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b1);
    endtask

    task automatic test_padding_boundaries();
        // lengths around the one-or-two block padding split
        send_message(54);
        send_message(55);
        wait_drained();
        send_message(56);
        // final item that completes a block
        for (int k = 0; k < 63; k++) send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b1);
        send_message(64);
    endtask

    task automatic test_random_messages();
        int total, len;
        total = 0;
        while (total < 110) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(60, 140);
                1: begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                    total += 1;
                    len = $urandom_range(0, 8);
                end
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len);
            total += len + 1;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        int guard;
        error_count      = 0;
        receiver_running = 1'b0;
        reset_digest_state();
        for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_byte    <= 8'h00;
        in_present <= 1'b0;
        in_eom     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        receiver_running = 1'b1;
        @(posedge clk);

        test_empty_message();
        test_directed_bytes();
        test_padding_boundaries();
        wait_drained();
        test_random_messages();
        release_input();

        guard = 0;
        while (digest_queue.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/sha256_pkg.sv
sv/sha256_stream_hasher_top.sv
sv/sha256_stream_hasher_chk.sv
tb/sv/tb_sha256_stream_hasher_top.sv
